// ===== src/assert_macros.svh =====
// Assertion helpers, clocked on clk, disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define RPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rms_power_from_sums: implication check failed");

// Next-cycle implication.
`define RPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rms_power_from_sums: next-cycle check failed");

`endif

// ===== src/rps_pkg.sv =====
package rps_pkg;

	localparam int NUM_W      = 63;  // dividend / quotient width
	localparam int DEN_W      = 26;  // divisor width
	localparam int ROOT_W     = 32;
	localparam int SREM_W     = ROOT_W + 2;
	localparam int M_W        = 57;  // mean product quotient width
	localparam int DIV_CELLS  = NUM_W;
	localparam int SQRT_CELLS = ROOT_W;
	localparam int LANES      = 3;   // voltage, current, real power

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_MEASURED = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLTS_PER_CODE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMPS_PER_CODE    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAINS_RMS        = 2'd3;

	localparam logic [19:0] MAINS_RMS_RESET = 20'd58880;

	typedef struct packed {
		logic [3:0]  channel;
		logic [31:0] stamp;
		logic        v_zero;
		logic        i_zero;
		logic        r_neg;
	} side_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
	} div_lane_t;

	typedef struct packed {
		logic [2*ROOT_W-1:0] x;
		logic [SREM_W-1:0]   rem;
		logic [ROOT_W-1:0]   root;
	} sqrt_lane_t;

endpackage

// ===== src/rps_div_cell.sv =====
// One restoring-division step per lane: one quotient bit enters num's lsb.
module rps_div_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  rps_pkg::side_t                         in_side,
	input  rps_pkg::div_lane_t [rps_pkg::LANES-1:0] in_lane,
	output logic                                   out_valid,
	output rps_pkg::side_t                         out_side,
	output rps_pkg::div_lane_t [rps_pkg::LANES-1:0] out_lane
);

	logic                                    valid_q;
	rps_pkg::side_t                          side_q;
	rps_pkg::div_lane_t [rps_pkg::LANES-1:0] lane_q;
	rps_pkg::div_lane_t [rps_pkg::LANES-1:0] lane_d;

	always_comb begin
		logic [rps_pkg::DEN_W:0] t;
		logic [rps_pkg::DEN_W:0] diff;
		logic                    ge;
		for (int k = 0; k < rps_pkg::LANES; k++) begin
			t    = {in_lane[k].rem, in_lane[k].num[rps_pkg::NUM_W-1]};
			diff = t - {1'b0, in_lane[k].den};
			ge   = t >= {1'b0, in_lane[k].den};
			lane_d[k].den = in_lane[k].den;
			lane_d[k].rem = ge ? diff[rps_pkg::DEN_W-1:0] : t[rps_pkg::DEN_W-1:0];
			lane_d[k].num = {in_lane[k].num[rps_pkg::NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			lane_q <= lane_d;
		end
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_lane  = lane_q;

endmodule

// ===== src/rps_sqrt_cell.sv =====
// One bit-pair step of an integer square root for the voltage and current lanes.
module rps_sqrt_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_valid,
	input  rps_pkg::side_t                     in_side,
	input  logic [rps_pkg::M_W-1:0]            in_m,
	input  rps_pkg::sqrt_lane_t [1:0]          in_lane,
	output logic                               out_valid,
	output rps_pkg::side_t                     out_side,
	output logic [rps_pkg::M_W-1:0]            out_m,
	output rps_pkg::sqrt_lane_t [1:0]          out_lane
);

	logic                          valid_q;
	rps_pkg::side_t                side_q;
	logic [rps_pkg::M_W-1:0]       m_q;
	rps_pkg::sqrt_lane_t [1:0]     lane_q;
	rps_pkg::sqrt_lane_t [1:0]     lane_d;

	always_comb begin
		logic [rps_pkg::SREM_W+1:0] cand;
		logic [rps_pkg::SREM_W+1:0] trial;
		logic [rps_pkg::SREM_W+1:0] diff;
		logic                       ge;
		for (int k = 0; k < 2; k++) begin
			cand  = {in_lane[k].rem, in_lane[k].x[2*rps_pkg::ROOT_W-1 -: 2]};
			trial = {2'b00, in_lane[k].root, 2'b01};
			diff  = cand - trial;
			ge    = cand >= trial;
			lane_d[k].x    = {in_lane[k].x[2*rps_pkg::ROOT_W-3:0], 2'b00};
			lane_d[k].rem  = ge ? diff[rps_pkg::SREM_W-1:0] : cand[rps_pkg::SREM_W-1:0];
			lane_d[k].root = {in_lane[k].root[rps_pkg::ROOT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= in_side;
			m_q    <= in_m;
			lane_q <= lane_d;
		end
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_m     = m_q;
	assign out_lane  = lane_q;

endmodule

// ===== src/rms_power_from_sums.sv =====
// RMS and power from accumulated sample sums. One channel snapshot enters per
// cycle while the pipe is not halted, and passes a products stage, a
// differences stage, a chain of 63 divider cells (one quotient bit per cell,
// three lanes side by side), a chain of 32 square-root cells (one root bit
// per cell) and stages for scaling, power products and saturation. The whole
// pipe moves together and halts only while a result waits on m_tready.
// Outputs carry 8 fraction bits; a zero voltage or current count gives zero RMS.
// The configuration is read late in the pipe: write cfg_* only while no
// transaction is in flight.
`include "assert_macros.svh"

module rms_power_from_sums (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rps_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// channel, stamp_ms, v_count, v_sum, v_sum_sq, i_count, i_sum, i_sum_sq, vi_sum
	input  logic [223:0]                     s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// out_channel, out_stamp_ms, volt_rms, amp_rms, apparent_power, active_power
	output logic [143:0]                     m_tdata
);

	localparam int DC = rps_pkg::DIV_CELLS;
	localparam int SC = rps_pkg::SQRT_CELLS;

	// configuration
	logic        voltage_measured_q;
	logic [23:0] vpc_q;
	logic [23:0] apc_q;
	logic [19:0] mains_q;
	logic [47:0] coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voltage_measured_q <= 1'b0;
			vpc_q              <= '0;
			apc_q              <= '0;
			mains_q            <= rps_pkg::MAINS_RMS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rps_pkg::REG_VOLTAGE_MEASURED: voltage_measured_q <= cfg_data[0];
				rps_pkg::REG_VOLTS_PER_CODE:   vpc_q              <= cfg_data;
				rps_pkg::REG_AMPS_PER_CODE:    apc_q              <= cfg_data;
				rps_pkg::REG_MAINS_RMS:        mains_q            <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		coef_q <= vpc_q * apc_q;
	end

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input fields
	logic [3:0]  in_channel;
	logic [31:0] in_stamp;
	logic [12:0] nv, ni;
	logic [23:0] vs, is_;
	logic [35:0] vq, iq, vi;
	assign in_channel = s_tdata[3:0];
	assign in_stamp   = s_tdata[35:4];
	assign nv         = s_tdata[48:36];
	assign vs         = s_tdata[72:49];
	assign vq         = s_tdata[108:73];
	assign ni         = s_tdata[121:109];
	assign is_        = s_tdata[145:122];
	assign iq         = s_tdata[181:146];
	assign vi         = s_tdata[217:182];

	// stage 1: products
	logic        valid_s1;
	rps_pkg::side_t side_s1;
	logic [48:0] qn_v_s1, qn_i_s1, pos_s1;
	logic [47:0] ss_v_s1, ss_i_s1, neg_s1;
	logic [25:0] nn_v_s1, nn_i_s1, nvi_s1;
	logic [35:0] vi_s1;
	logic [12:0] ni_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.channel <= in_channel;
			side_s1.stamp   <= in_stamp;
			side_s1.v_zero  <= nv == '0;
			side_s1.i_zero  <= ni == '0;
			side_s1.r_neg   <= 1'b0;
			qn_v_s1 <= vq * nv;
			qn_i_s1 <= iq * ni;
			ss_v_s1 <= vs * vs;
			ss_i_s1 <= is_ * is_;
			nn_v_s1 <= nv * nv;
			nn_i_s1 <= ni * ni;
			pos_s1  <= vi * nv;
			neg_s1  <= vs * is_;
			nvi_s1  <= nv * ni;
			vi_s1   <= vi;
			ni_s1   <= ni;
		end
	end

	// stage 2: differences, divider lane setup
	logic [48:0] d_v, d_i, p_r, n_r, mag_r;
	logic [25:0] den_r;
	assign d_v   = (qn_v_s1 > {1'b0, ss_v_s1}) ? qn_v_s1 - {1'b0, ss_v_s1} : '0;
	assign d_i   = (qn_i_s1 > {1'b0, ss_i_s1}) ? qn_i_s1 - {1'b0, ss_i_s1} : '0;
	assign p_r   = side_s1.v_zero ? {13'd0, vi_s1} : pos_s1;
	assign n_r   = side_s1.v_zero ? '0 : {1'b0, neg_s1};
	assign den_r = side_s1.v_zero ? {13'd0, ni_s1} : nvi_s1;
	assign mag_r = (p_r >= n_r) ? p_r - n_r : n_r - p_r;

	logic                                   dv [0:DC];
	rps_pkg::side_t                         ds [0:DC];
	rps_pkg::div_lane_t [rps_pkg::LANES-1:0] dl [0:DC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv[0] <= 1'b0;
		end else if (en) begin
			dv[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ds[0]    <= '{channel: side_s1.channel, stamp: side_s1.stamp,
				v_zero: side_s1.v_zero, i_zero: side_s1.i_zero, r_neg: (p_r < n_r)};
			dl[0][0] <= '{num: {d_v, 14'd0}, rem: '0, den: nn_v_s1};
			dl[0][1] <= '{num: {d_i, 14'd0}, rem: '0, den: nn_i_s1};
			dl[0][2] <= '{num: {6'd0, mag_r, 8'd0}, rem: '0, den: den_r};
		end
	end

	for (genvar g = 0; g < DC; g++) begin : g_div
		rps_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dv[g]),
			.in_side  (ds[g]),
			.in_lane  (dl[g]),
			.out_valid(dv[g+1]),
			.out_side (ds[g+1]),
			.out_lane (dl[g+1])
		);
	end

	logic                      sv [0:SC];
	rps_pkg::side_t            ss [0:SC];
	logic [rps_pkg::M_W-1:0]   sm [0:SC];
	rps_pkg::sqrt_lane_t [1:0] sl [0:SC];

	assign sv[0]    = dv[DC];
	assign ss[0]    = ds[DC];
	assign sm[0]    = dl[DC][2].num[rps_pkg::M_W-1:0];
	assign sl[0][0] = '{x: {1'b0, dl[DC][0].num}, rem: '0, root: '0};
	assign sl[0][1] = '{x: {1'b0, dl[DC][1].num}, rem: '0, root: '0};

	for (genvar g = 0; g < SC; g++) begin : g_sqrt
		rps_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sv[g]),
			.in_side  (ss[g]),
			.in_m     (sm[g]),
			.in_lane  (sl[g]),
			.out_valid(sv[g+1]),
			.out_side (ss[g+1]),
			.out_m    (sm[g+1]),
			.out_lane (sl[g+1])
		);
	end

	// stage 3: scale products and partial products of mean * coefficient
	logic        valid_s3;
	rps_pkg::side_t side_s3;
	logic [55:0] pv_s3, pi_s3;
	logic [63:0] p0_s3;
	logic [47:0] p1_s3;
	logic [56:0] p2_s3;
	logic [40:0] p3_s3;
	logic [31:0] ml;
	logic [24:0] mh;
	assign ml = sm[SC][31:0];
	assign mh = sm[SC][56:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= sv[SC];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= ss[SC];
			pv_s3   <= sl[SC][0].root * vpc_q;
			pi_s3   <= sl[SC][1].root * apc_q;
			p0_s3   <= ml * coef_q[31:0];
			p1_s3   <= ml * coef_q[47:32];
			p2_s3   <= mh * coef_q[31:0];
			p3_s3   <= mh * coef_q[47:32];
		end
	end

	// stage 4: RMS saturation, power sum
	logic        valid_s4;
	rps_pkg::side_t side_s4;
	logic [19:0] vrms_s4, irms_s4;
	logic [65:0] pr_s4;
	logic [36:0] v_sh, i_sh;
	logic [105:0] full;
	assign v_sh = pv_s3[55:19];
	assign i_sh = pi_s3[55:19];
	assign full = {42'd0, p0_s3} + {26'd0, p1_s3, 32'd0} + {17'd0, p2_s3, 32'd0}
		+ {1'b0, p3_s3, 64'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= side_s3;
			if (!voltage_measured_q || side_s3.v_zero) begin
				vrms_s4 <= '0;
			end else begin
				vrms_s4 <= (|v_sh[36:20]) ? '1 : v_sh[19:0];
			end
			if (side_s3.i_zero) begin
				irms_s4 <= '0;
			end else begin
				irms_s4 <= (|i_sh[36:20]) ? '1 : i_sh[19:0];
			end
			pr_s4 <= full[105:40];
		end
	end

	// stage 5: output register
	logic        valid_s5;
	rps_pkg::side_t side_s5;
	logic [19:0] vrms_s5, irms_s5;
	logic [31:0] app_s5, real_s5;
	logic [39:0] app_full;
	logic [31:0] cap, pmag;
	assign app_full = irms_s4 * (voltage_measured_q ? vrms_s4 : mains_q);
	assign cap      = side_s4.r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign pmag     = (pr_s4 > {34'd0, cap}) ? cap : pr_s4[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			vrms_s5 <= vrms_s4;
			irms_s5 <= irms_s4;
			app_s5  <= side_s4.i_zero ? '0 : app_full[39:8];
			if (side_s4.i_zero || !voltage_measured_q) begin
				real_s5 <= '0;
			end else begin
				real_s5 <= side_s4.r_neg ? 32'd0 - pmag : pmag;
			end
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = {4'd0, real_s5, app_s5, irms_s5, vrms_s5, side_s5.stamp,
		side_s5.channel};

	`RPS_ASSERT_IMP(a_ready_when_free, !m_tvalid, s_tready)
	`RPS_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, valid_s1)
	`RPS_ASSERT_IMP(a_unmeasured_zero, m_tvalid && !voltage_measured_q,
		m_tdata[55:36] == '0 && m_tdata[139:108] == '0)
	`RPS_ASSERT_IMP(a_no_current_zero, m_tvalid && side_s5.i_zero,
		m_tdata[75:56] == '0 && m_tdata[107:76] == '0)

endmodule

// ===== test/tb_rms_power_from_sums.sv =====
module tb_rms_power_from_sums;

	localparam int LATENCY_WAIT = 120;
	localparam int STALL_LIMIT  = 4000;

	// receiver back-pressure patterns
	localparam int STALL_NONE     = 0;
	localparam int STALL_RANDOM   = 1;
	localparam int STALL_PERIODIC = 2;
	localparam int STALL_HEAVY    = 3;

	// fields from the highest bit down, as on s_tdata / m_tdata
	typedef struct packed {
		logic [5:0]  pad;
		logic [35:0] vi_sum;
		logic [35:0] i_sum_sq;
		logic [23:0] i_sum;
		logic [12:0] i_count;
		logic [35:0] v_sum_sq;
		logic [23:0] v_sum;
		logic [12:0] v_count;
		logic [31:0] stamp_ms;
		logic [3:0]  channel;
	} snapshot_t;

	typedef struct packed {
		logic [3:0]  pad;
		logic [31:0] active_power;
		logic [31:0] apparent_power;
		logic [19:0] amp_rms;
		logic [19:0] volt_rms;
		logic [31:0] stamp_ms;
		logic [3:0]  channel;
	} power_t;

	class power_scoreboard;
		power_t    pending[$];
		int        errors;
		int        checked;
		bit        volt_meas;
		bit [23:0] v_scale;
		bit [23:0] a_scale;
		bit [19:0] mains;

		function new();
			errors = 0;
			checked = 0;
			volt_meas = 1'b0;
			v_scale = '0;
			a_scale = '0;
			mains = rps_pkg::MAINS_RMS_RESET;
		endfunction

		function bit [63:0] int_sqrt(bit [63:0] x);
			bit [63:0] root;
			bit [63:0] b;
			root = '0;
			b = 64'd1 << 62;
			while (b > x)
				b >>= 2;
			while (b != 0) begin
				if (x >= root + b) begin
					x = x - (root + b);
					root = (root >> 1) + b;
				end else begin
					root >>= 1;
				end
				b >>= 2;
			end
			return root;
		endfunction

		function bit [19:0] ac_rms(bit [63:0] n, bit [63:0] s, bit [63:0] q, bit [63:0] k);
			bit [63:0] a;
			bit [63:0] sq;
			bit [63:0] d;
			bit [63:0] r;
			if (n == 0)
				return '0;
			a = q * n;
			sq = s * s;
			d = (a > sq) ? a - sq : '0;
			r = int_sqrt((d << 14) / (n * n));
			r = (r * k) >> 19;
			return (r > 64'hFFFFF) ? 20'hFFFFF : r[19:0];
		endfunction

		function power_t predict(snapshot_t s);
			power_t    p;
			bit [63:0] pos, neg, mag, den, m, cap, capped, app;
			bit [127:0] prod;
			p = '0;
			p.channel = s.channel;
			p.stamp_ms = s.stamp_ms;
			if (volt_meas)
				p.volt_rms = ac_rms(64'(s.v_count), 64'(s.v_sum), 64'(s.v_sum_sq),
					64'(v_scale));
			if (s.i_count != 0) begin
				p.amp_rms = ac_rms(64'(s.i_count), 64'(s.i_sum), 64'(s.i_sum_sq),
					64'(a_scale));
				app = (64'(p.amp_rms) * 64'(volt_meas ? p.volt_rms : mains)) >> 8;
				p.apparent_power = app[31:0];
				if (volt_meas) begin
					if (s.v_count == 0) begin
						pos = 64'(s.vi_sum);
						neg = '0;
						den = 64'(s.i_count);
					end else begin
						pos = 64'(s.vi_sum) * s.v_count;
						neg = 64'(s.v_sum) * s.i_sum;
						den = 64'(s.v_count) * s.i_count;
					end
					mag = (pos >= neg) ? pos - neg : neg - pos;
					m = (mag << 8) / den;
					prod = (128'(m) * (128'(v_scale) * a_scale)) >> 40;
					cap = (pos >= neg) ? 64'h7FFFFFFF : 64'h80000000;
					capped = (prod > cap) ? cap : prod[63:0];
					p.active_power = (pos >= neg) ? capped[31:0] : -capped[31:0];
				end
			end
			return p;
		endfunction

		function void note_snapshot(snapshot_t s);
			pending.push_back(predict(s));
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch %s: got %0h expected %0h", what, got, want);
		endtask

		task check_result(power_t got);
			power_t want;
			if (pending.size() == 0) begin
				report("unexpected transaction", 64'(got.channel), '0);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.channel !== want.channel)
				report("out_channel", 64'(got.channel), 64'(want.channel));
			if (got.stamp_ms !== want.stamp_ms)
				report("out_stamp_ms", 64'(got.stamp_ms), 64'(want.stamp_ms));
			if (got.volt_rms !== want.volt_rms)
				report("volt_rms", 64'(got.volt_rms), 64'(want.volt_rms));
			if (got.amp_rms !== want.amp_rms)
				report("amp_rms", 64'(got.amp_rms), 64'(want.amp_rms));
			if (got.apparent_power !== want.apparent_power)
				report("apparent_power", 64'(got.apparent_power),
					64'(want.apparent_power));
			if (got.active_power !== want.active_power)
				report("active_power", 64'(got.active_power), 64'(want.active_power));
		endtask
	endclass

	logic                           clk = 0;
	logic                           arst_n = 0;
	logic                           cfg_we = 0;
	logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           s_tvalid = 0;
	logic                           s_tready;
	logic [223:0]                   s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 0;
	logic [143:0]                   m_tdata;

	power_scoreboard sb = new();
	int  idle_cycles = 0;
	int  burst_left = 0;
	bit  no_gaps = 0;
	int  stall_mode = 0;
	int  stall_phase = 0;
	int  sent = 0;

	rms_power_from_sums i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	// receiver back-pressure: random, periodic, heavy or none, switched per phase
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			STALL_NONE: begin
				m_tready <= 1'b1;
			end
			STALL_RANDOM: begin
				m_tready <= ($urandom_range(0, 9) < 7);
			end
			STALL_PERIODIC: begin
				m_tready <= (stall_phase % 7) < 3;
			end
			default: begin
				m_tready <= ($urandom_range(0, 9) < 2);
			end
		endcase
	end

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_snapshot(snapshot_t'(s_tdata));
		if (m_tvalid && m_tready)
			sb.check_result(power_t'(m_tdata));
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
				$display("tb_rms_power_from_sums NOT OK");
				$finish;
			end
		end
	end

	task write_reg(logic [rps_pkg::CFG_IDX_W-1:0] idx,
		logic [rps_pkg::CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			rps_pkg::REG_VOLTAGE_MEASURED: sb.volt_meas = value[0];
			rps_pkg::REG_VOLTS_PER_CODE:   sb.v_scale = value;
			rps_pkg::REG_AMPS_PER_CODE:    sb.a_scale = value;
			rps_pkg::REG_MAINS_RMS:        sb.mains = value[19:0];
			default: ;
		endcase
	endtask

	task configure(bit meas, bit [23:0] vk, bit [23:0] ak, bit [19:0] mains_v);
		write_reg(rps_pkg::REG_VOLTAGE_MEASURED, {23'd0, meas});
		write_reg(rps_pkg::REG_VOLTS_PER_CODE, vk);
		write_reg(rps_pkg::REG_AMPS_PER_CODE, ak);
		write_reg(rps_pkg::REG_MAINS_RMS, {4'd0, mains_v});
		cfg_we <= 1'b0;
	endtask

	task send(snapshot_t s);
		if (burst_left == 0 && !no_gaps) begin
			int gap;
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= 224'(s);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	function logic [35:0] rand36();
		return 36'({$urandom, $urandom});
	endfunction

	// consistent sums of a sine-like signal around a bias
	function snapshot_t shaped_snapshot();
		snapshot_t s;
		int unsigned n, ni, bv, bi, av, ai;
		logic [63:0] t;
		s = '0;
		s.channel = 4'($urandom);
		s.stamp_ms = $urandom;
		case ($urandom_range(0, 9))
			0: n = $urandom_range(4000, 8191);
			1: n = 0;
			default: n = $urandom_range(1, 300);
		endcase
		ni = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : n;
		bv = $urandom_range(0, 4095);
		bi = $urandom_range(0, 4095);
		av = $urandom_range(0, 2047);
		ai = $urandom_range(0, 2047);
		s.v_count = 13'(n);
		s.i_count = 13'(ni);
		t = 64'(n) * bv;
		s.v_sum = t[23:0];
		t = 64'(n) * (64'(bv) * bv + (64'(av) * av) / 2);
		s.v_sum_sq = t[35:0];
		t = 64'(ni) * bi;
		s.i_sum = t[23:0];
		t = 64'(ni) * (64'(bi) * bi + (64'(ai) * ai) / 2);
		s.i_sum_sq = t[35:0];
		t = 64'(ni) * 64'(bv) * bi;
		if ($urandom_range(0, 1))
			t = t + 64'(ni) * ((64'(av) * ai) / 2) / ($urandom_range(1, 4));
		else
			t = t - ((64'(ni) * ((64'(av) * ai) / 2)) % (t + 1));
		s.vi_sum = t[35:0];
		return s;
	endfunction

	function snapshot_t noise_snapshot();
		snapshot_t s;
		s = '0;
		s.channel = 4'($urandom);
		s.stamp_ms = $urandom;
		s.v_count = 13'($urandom);
		s.v_sum = 24'($urandom);
		s.v_sum_sq = rand36();
		s.i_count = 13'($urandom);
		s.i_sum = 24'($urandom);
		s.i_sum_sq = rand36();
		s.vi_sum = rand36();
		return s;
	endfunction

	task directed_items();
		snapshot_t s;
		s = '0;
		send(s);                              // all zero counts
		s.channel = 4'hF;
		s.stamp_ms = 32'hFFFFFFFF;
		s.v_count = 13'h1FFF;
		s.v_sum = 24'hFFFFFF;
		s.v_sum_sq = 36'hFFFFFFFFF;
		s.i_count = 13'h1FFF;
		s.i_sum = 24'hFFFFFF;
		s.i_sum_sq = 36'hFFFFFFFFF;
		s.vi_sum = 36'hFFFFFFFFF;
		send(s);                              // every field at its top
		s.v_count = 13'd1;
		s.i_count = 13'd1;
		s.v_sum = 24'd4095;
		s.v_sum_sq = 36'd4095 * 36'd4095;
		s.i_sum = 24'd4095;
		s.i_sum_sq = 36'd4095 * 36'd4095;
		s.vi_sum = 36'd4095 * 36'd4095;
		send(s);                              // single sample, no AC part
		s.v_count = '0;
		send(s);                              // no voltage samples
		s.v_count = 13'd4096;
		s.i_count = '0;
		send(s);                              // no current samples
		s.channel = 4'd4;
		s.v_count = 13'd4096;
		s.i_count = 13'd4096;
		s.v_sum = 24'd4096 * 24'd2048;
		s.i_sum = 24'd4096 * 24'd2048;
		s.v_sum_sq = 36'd4096 * (2048 * 2048 + 2047 * 2047 / 2);
		s.i_sum_sq = 36'd4096 * (2048 * 2048 + 2047 * 2047 / 2);
		s.vi_sum = 36'd4096 * (2048 * 2048 + 2047 * 2047 / 2);
		send(s);                              // full-scale sine, in phase
		s.vi_sum = 36'd4096 * (2048 * 2048 - 2047 * 2047 / 2);
		send(s);                              // antiphase: negative real power
		s.vi_sum = '0;
		send(s);                              // strongly negative mean product
		s.v_sum_sq = '0;
		s.i_sum_sq = '0;
		send(s);                              // mean square below squared mean
		s.v_count = 13'd8191;
		s.i_count = 13'd4097;
		s.channel = 4'd9;
		send(s);                              // counts above the nominal maximum
		repeat (6)
			send(noise_snapshot());
	endtask

	task random_items(int count);
		repeat (count) begin
			if ($urandom_range(0, 3) == 0)
				send(noise_snapshot());
			else
				send(shaped_snapshot());
		end
	endtask

	task run_phase(bit meas, bit [23:0] vk, bit [23:0] ak, bit [19:0] mains_v, int mode);
		stall_mode = mode;
		no_gaps = (mode == STALL_NONE);
		configure(meas, vk, ak, mains_v);
		directed_items();
		random_items(150);
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset configuration first
		stall_mode = STALL_RANDOM;
		directed_items();
		random_items(60);
		drain();
		run_phase(1'b1, 24'h100000, 24'h010000, 20'd58880, STALL_RANDOM);
		run_phase(1'b1, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, STALL_PERIODIC);
		run_phase(1'b0, 24'($urandom), 24'($urandom), 20'd0, STALL_HEAVY);
		run_phase(1'b1, 24'd0, 24'd0, 20'hFFFFF, STALL_NONE);
		run_phase(1'b1, 24'($urandom), 24'($urandom), 20'($urandom), STALL_RANDOM);
		run_phase(1'b0, 24'h004000, 24'hFFFFFF, 20'hFFFFF, STALL_PERIODIC);
		$display("sent %0d snapshots, checked %0d results over 7 register settings",
			sent, sb.checked);
		$display("covered measured and fixed mains voltage, zero counts, saturation, stalls");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_rms_power_from_sums OK");
		else
			$display("tb_rms_power_from_sums NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+src
src/rps_pkg.sv
src/rps_div_cell.sv
src/rps_sqrt_cell.sv
src/rms_power_from_sums.sv
test/tb_rms_power_from_sums.sv
